// ===== hdl/stbs_pkg.sv =====
package stbs_pkg;

    // table geometry
    localparam int DEPTH      = 1024;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = $clog2(DEPTH);
    // entry count runs 0 .. DEPTH inclusive
    localparam int CNT_W      = ADDR_W + 1;
    // result position field width is fixed by the interface
    localparam int POS_W      = 11;
    localparam int FUNC_W     = 2;

    // operation codes carried on the func field
    typedef enum logic [FUNC_W-1:0] {
        FUNC_LOAD   = 2'd0,
        FUNC_SEARCH = 2'd1,
        FUNC_CLEAR  = 2'd2
    } func_t;

endpackage

// ===== hdl/stbs_ram.sv =====
module stbs_ram #(
    parameter int DEPTH  = 1024,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hdl/sorted_table_binary_search.sv =====
// Sorted table with binary search. Load transactions append a signed value at
// the next free slot (dropped once the table holds DEPTH entries) and clear
// transactions empty the table; neither ever produces a result. A search
// transaction produces exactly one result: found and the matching index, or
// found low and position -1. Each probe of the table memory waits on its
// registered read before the bounds are updated. If the previous result is
// still waiting on the result channel when the search ends, the new result is
// parked until the output register is free. No new transaction is taken during
// a search or while its result is parked.
// Entries must be loaded in ascending signed order for the search to be
// meaningful; the table memory needs no initialization after reset.
module sorted_table_binary_search
    import stbs_pkg::*;
(
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [FUNC_W-1:0]            s_func,
    input  logic signed [DATA_WIDTH-1:0] s_value,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_found,
    output logic signed [POS_W-1:0]      m_position
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SRCH,
        ST_DONE
    } state_t;

    state_t                  state_reg, state_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [CNT_W-1:0]        lo_reg, lo_next;
    logic [CNT_W-1:0]        hx_reg, hx_next;
    logic [ADDR_W-1:0]       mid_reg, mid_next;
    logic [DATA_WIDTH-1:0]   key_reg, key_next;
    logic                    res_found_reg, res_found_next;
    logic [POS_W-1:0]        res_pos_reg, res_pos_next;
    logic                    m_valid_reg, m_valid_next;
    logic                    m_found_reg, m_found_next;
    logic [POS_W-1:0]        m_pos_reg, m_pos_next;

    logic                    ram_we;
    logic                    ram_re;
    logic [DATA_WIDTH-1:0]   ram_rdata;
    logic                    accept;
    logic                    out_free;
    logic                    fin;
    logic                    fin_found;
    logic [POS_W-1:0]        fin_pos;
    logic [CNT_W-1:0]        lo_upd, hx_upd;
    logic [CNT_W-1:0]        span;

    stbs_ram #(
        .DEPTH  (DEPTH),
        .WIDTH  (DATA_WIDTH),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata (s_value),
        .re    (ram_re),
        .raddr (mid_next),
        .rdata (ram_rdata)
    );

    assign s_ready    = (state_reg == ST_IDLE);
    assign accept     = s_valid && s_ready;
    assign out_free   = !m_valid_reg || m_ready;
    assign m_valid    = m_valid_reg;
    assign m_found    = m_found_reg;
    assign m_position = m_pos_reg;

    // bound update after one probe
    always_comb begin
        lo_upd = lo_reg;
        hx_upd = hx_reg;
        if ($signed(ram_rdata) < $signed(key_reg)) begin
            lo_upd = {1'b0, mid_reg} + CNT_W'(1);
        end else begin
            hx_upd = {1'b0, mid_reg};
        end
        span = hx_upd - lo_upd - CNT_W'(1);
    end

    // control and probe sequencing
    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        lo_next        = lo_reg;
        hx_next        = hx_reg;
        mid_next       = mid_reg;
        key_next       = key_reg;
        res_found_next = res_found_reg;
        res_pos_next   = res_pos_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_found_next   = m_found_reg;
        m_pos_next     = m_pos_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        fin            = 1'b0;
        fin_found      = 1'b0;
        fin_pos        = '1;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (s_func)
                        FUNC_LOAD: begin
                            if (count_reg < CNT_W'(DEPTH)) begin
                                ram_we     = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        FUNC_CLEAR: begin
                            count_next = '0;
                        end
                        FUNC_SEARCH: begin
                            key_next = s_value;
                            if (count_reg == '0) begin
                                fin = 1'b1;
                            end else begin
                                lo_next    = '0;
                                hx_next    = count_reg;
                                mid_next   = ADDR_W'((count_reg - CNT_W'(1)) >> 1);
                                ram_re     = 1'b1;
                                state_next = ST_SRCH;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SRCH: begin
                if (ram_rdata == key_reg) begin
                    fin       = 1'b1;
                    fin_found = 1'b1;
                    fin_pos   = POS_W'(mid_reg);
                end else if (lo_upd >= hx_upd) begin
                    fin = 1'b1;
                end else begin
                    lo_next  = lo_upd;
                    hx_next  = hx_upd;
                    mid_next = ADDR_W'(lo_upd + (span >> 1));
                    ram_re   = 1'b1;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_found_next = res_found_reg;
                    m_pos_next   = res_pos_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // hand the result to the output register, or park it
        if (fin) begin
            if (out_free) begin
                m_valid_next = 1'b1;
                m_found_next = fin_found;
                m_pos_next   = fin_pos;
                state_next   = ST_IDLE;
            end else begin
                res_found_next = fin_found;
                res_pos_next   = fin_pos;
                state_next     = ST_DONE;
            end
        end
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        lo_reg        <= lo_next;
        hx_reg        <= hx_next;
        mid_reg       <= mid_next;
        key_reg       <= key_next;
        res_found_reg <= res_found_next;
        res_pos_reg   <= res_pos_next;
        m_found_reg   <= m_found_next;
        m_pos_reg     <= m_pos_next;
    end

endmodule

// ===== hdl/stbs_checker.sv =====
module stbs_checker
    import stbs_pkg::*;
(
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_valid,
    input logic                         s_ready,
    input logic [FUNC_W-1:0]            s_func,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic                         m_found,
    input logic signed [POS_W-1:0]      m_position
);

    // a stalled result holds its payload
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_found) && $stable(m_position))
        else $error("stalled result changed");

    // a miss always reports position -1
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_found |-> m_position == '1)
        else $error("miss without position -1");

    // a hit reports a non-negative index
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_found |-> !m_position[POS_W-1])
        else $error("hit with negative position");

    // a search transaction answers at once or holds off the input
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_func == FUNC_SEARCH |=> !s_ready || m_valid)
        else $error("input taken during search");

    // reset empties the result channel
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind sorted_table_binary_search stbs_checker u_stbs_checker (.*);

// ===== verif/tb_sorted_table_binary_search.sv =====
module tb_sorted_table_binary_search;
    timeunit 1ns;
    timeprecision 1ps;

    import stbs_pkg::*;

    // func code that the block ignores
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
    // cycles without any transaction before the run is declared hung
    localparam int HANG_LIMIT = 2000;
    // settle time after the last result
    localparam int DRAIN_CYCLES = 40;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic                    found;
        logic signed [POS_W-1:0] position;
    } search_result_t;

    // table mirror, binary search predictor and result checking
    class search_scoreboard;
        logic signed [DATA_WIDTH-1:0] table_mem [DEPTH];
        int unsigned                  fill_level;
        search_result_t               expected_q [$];
        int                           mismatch_count;

        function new();
            fill_level     = 0;
            mismatch_count = 0;
        endfunction

        function search_result_t bisect(logic signed [DATA_WIDTH-1:0] key);
            int lo;
            int hi;
            int mid;
            search_result_t r;
            lo         = 0;
            hi         = int'(fill_level) - 1;
            r.found    = 1'b0;
            r.position = '1;
            while (lo <= hi) begin
                mid = lo + (hi - lo) / 2;
                if (table_mem[mid] == key) begin
                    r.found    = 1'b1;
                    r.position = POS_W'(mid);
                    return r;
                end
                if (table_mem[mid] < key)
                    lo = mid + 1;
                else
                    hi = mid - 1;
            end
            return r;
        endfunction

        // update the mirror for one accepted input transaction
        function void note_transaction(logic [FUNC_W-1:0] f,
                                       logic signed [DATA_WIDTH-1:0] v);
            case (f)
                FUNC_LOAD: begin
                    if (fill_level < DEPTH) begin
                        table_mem[fill_level] = v;
                        fill_level++;
                    end
                end
                FUNC_CLEAR: fill_level = 0;
                FUNC_SEARCH: expected_q.push_back(bisect(v));
                default: ;
            endcase
        endfunction

        function void report(string msg);
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("%s", msg);
        endfunction

        // compare one accepted result with the oldest expected one
        function void check_result(logic found, logic signed [POS_W-1:0] position);
            search_result_t exp_r;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected search result: found=%0b position=%0d",
                                 found, position));
                return;
            end
            exp_r = expected_q.pop_front();
            if (found !== exp_r.found)
                report($sformatf("found mismatch: expected %0b, got %0b",
                                 exp_r.found, found));
            if (position !== exp_r.position)
                report($sformatf("position mismatch: expected %0d, got %0d",
                                 exp_r.position, position));
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                         aclk       = 1'b0;
    logic                         aresetn    = 1'b0;
    logic                         s_valid    = 1'b0;
    logic                         s_ready;
    logic [FUNC_W-1:0]            s_func     = FUNC_LOAD;
    logic signed [DATA_WIDTH-1:0] s_value    = '0;
    logic                         m_valid;
    logic                         m_ready    = 1'b1;
    logic                         m_found;
    logic signed [POS_W-1:0]      m_position;

    search_scoreboard sb = new();
    bit               idle_on = 1'b1;
    int               items_sent = 0;
    int               stall_left = 0;
    int               quiet_cycles = 0;

    sorted_table_binary_search dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_func     (s_func),
        .s_value    (s_value),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_found    (m_found),
        .m_position (m_position)
    );

    // 2 ns clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // present one transaction and hold it until it is accepted
    task automatic send_item(input logic [FUNC_W-1:0] f,
                             input logic signed [DATA_WIDTH-1:0] v);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_func  <= f;
        s_value <= v;
        do @(posedge aclk); while (!s_ready);
        sb.note_transaction(f, v);
        if (f != FUNC_UNUSED)
            items_sent++;
    endtask

    // append n values, ascending (duplicates allowed) or in random order
    task automatic load_run(input int n, input bit sorted, input bit from_min,
                            input int unsigned max_step);
        longint cur;
        longint step;
        cur = from_min ? -64'sd2147483648 : longint'($signed($urandom));
        for (int i = 0; i < n; i++) begin
            if (i > 0) begin
                case ($urandom_range(0, 3))
                    0: step = 0;
                    1: step = $urandom_range(1, 3);
                    2: step = $urandom_range(1, 1 << 16);
                    default: step = $urandom_range(1, max_step);
                endcase
                cur = cur + step;
                if (cur > 64'sd2147483647)
                    cur = 64'sd2147483647;
            end
            if (sorted)
                send_item(FUNC_LOAD, DATA_WIDTH'(cur));
            else
                send_item(FUNC_LOAD, $urandom);
        end
    endtask

    // search key: present entries half the time, else near misses, extremes, noise
    function automatic logic signed [DATA_WIDTH-1:0] random_key();
        int pick;
        logic signed [DATA_WIDTH-1:0] k;
        pick = $urandom_range(0, 9);
        if (sb.fill_level == 0 && pick < 6)
            pick = 9;
        if (pick < 5) begin
            k = sb.table_mem[$urandom_range(0, sb.fill_level - 1)];
        end else if (pick == 5) begin
            k = sb.table_mem[$urandom_range(0, sb.fill_level - 1)];
            k = $urandom_range(0, 1) ? k + 1 : k - 1;
        end else if (pick == 6) begin
            k = $urandom_range(0, 1) ? {1'b1, {(DATA_WIDTH-1){1'b0}}}
                                     : {1'b0, {(DATA_WIDTH-1){1'b1}}};
        end else begin
            k = $urandom;
        end
        return k;
    endfunction

    // blocks of clear, small table load and searches, with some noise
    task automatic random_phase(input int target);
        int start;
        int n;
        start = items_sent;
        while (items_sent - start < target) begin
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 6)) begin
                    send_item(FUNC_W'($urandom_range(0, 3)),
                              $urandom_range(0, 1) ? random_key() : $urandom);
                end
            end else begin
                send_item(FUNC_CLEAR, $urandom);
                n = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 24);
                load_run(n, $urandom_range(0, 6) != 0, $urandom_range(0, 4) == 0,
                         32'h0fff_ffff);
                repeat ($urandom_range(1, 8)) send_item(FUNC_SEARCH, random_key());
                if ($urandom_range(0, 5) == 0)
                    send_item(FUNC_UNUSED, $urandom);
            end
        end
    endtask

    // result side: check accepted results and stall in random bursts
    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready)
                sb.check_result(m_found, m_position);
            if (!idle_on) begin
                m_ready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if ($urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(1, 4) - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // hang detection: cycles in which no transaction completes
    initial begin
        while (quiet_cycles < HANG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("tb: failure");
        $finish;
    end

    // stimulus
    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty table, extremes, duplicates, ignored code
        send_item(FUNC_SEARCH, 32'sd0);
        send_item(FUNC_UNUSED, 32'hffff_ffff);
        send_item(FUNC_LOAD, 32'h8000_0000);
        send_item(FUNC_LOAD, -32'sd1);
        send_item(FUNC_LOAD, 32'sd0);
        send_item(FUNC_LOAD, 32'sd0);
        send_item(FUNC_LOAD, 32'sd5);
        send_item(FUNC_LOAD, 32'h7fff_ffff);
        send_item(FUNC_SEARCH, 32'h8000_0000);
        send_item(FUNC_SEARCH, 32'h7fff_ffff);
        send_item(FUNC_SEARCH, 32'sd0);
        send_item(FUNC_SEARCH, 32'sd5);
        send_item(FUNC_SEARCH, -32'sd1);
        send_item(FUNC_SEARCH, 32'sd1);
        send_item(FUNC_SEARCH, 32'h8000_0001);
        send_item(FUNC_UNUSED, 32'sd5);
        send_item(FUNC_SEARCH, 32'sd5);
        // search after clear sees an empty table
        send_item(FUNC_CLEAR, 32'sd0);
        send_item(FUNC_SEARCH, 32'sd5);
        // out-of-order table still follows the probe path
        send_item(FUNC_LOAD, 32'sd10);
        send_item(FUNC_LOAD, 32'sd3);
        send_item(FUNC_LOAD, 32'sd7);
        send_item(FUNC_SEARCH, 32'sd3);
        send_item(FUNC_SEARCH, 32'sd10);

        random_phase(120);

        // hold off until every search has answered
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);

        // full table, loads past capacity are dropped, deep searches
        send_item(FUNC_CLEAR, $urandom);
        load_run(DEPTH, 1'b1, 1'b1, 32'd8_000_000);
        send_item(FUNC_LOAD, $urandom);
        send_item(FUNC_LOAD, 32'h8000_0000);
        send_item(FUNC_LOAD, 32'h7fff_ffff);
        repeat (40) send_item(FUNC_SEARCH, random_key());

        // last stretch at full rate
        idle_on = 1'b0;
        random_phase(100);

        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (sb.mismatch_count == 0 && sb.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/stbs_pkg.sv
hdl/stbs_ram.sv
hdl/sorted_table_binary_search.sv
hdl/stbs_checker.sv
verif/tb_sorted_table_binary_search.sv
